// File: hw/rtl/two_coil_follower_pwm_drive_unit_macros.svh
// Assertion helpers for the asserting module.
`ifndef TWO_COIL_FOLLOWER_PWM_DRIVE_UNIT_MACROS_SVH
`define TWO_COIL_FOLLOWER_PWM_DRIVE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TCFPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcfpd same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TCFPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcfpd next-cycle check failed");

`endif

// File: hw/rtl/tcfpd_pkg.sv
package tcfpd_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int CHANNELS        = 4;
    localparam int DUTY_BITS       = 7;

    localparam logic [DUTY_BITS-1:0] DRIVE_DUTY_RST = 7'd100;
    localparam logic [DUTY_BITS-1:0] PWM_TOP_RST    = 7'd100;

    // Configuration register indexes
    localparam logic CFG_DRIVE_DUTY = 1'b0;
    localparam logic CFG_PWM_TOP    = 1'b1;

    // Command characters
    localparam logic [7:0] CMD_UP    = 8'h75;
    localparam logic [7:0] CMD_DOWN  = 8'h64;
    localparam logic [7:0] CMD_LEFT  = 8'h6C;
    localparam logic [7:0] CMD_RIGHT = 8'h72;
    localparam logic [7:0] CMD_STOP  = 8'h73;

    typedef enum logic [1:0] {
        FN_TICK   = 2'd0,
        FN_CMD    = 2'd1,
        FN_SAMPLE = 2'd2,
        FN_TOGGLE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        MOT_STOP  = 3'd0,
        MOT_UP    = 3'd1,
        MOT_DOWN  = 3'd2,
        MOT_LEFT  = 3'd3,
        MOT_RIGHT = 3'd4
    } motion_t;

    typedef struct packed {
        logic [CHANNELS-1:0] pins;
        logic                follow;
        motion_t             motion;
    } result_t;

    // Channels driven by each motion
    function automatic logic [CHANNELS-1:0] motion_mask(input motion_t m);
        logic [CHANNELS-1:0] mask;
        begin
            case (m)
                MOT_UP:    mask = 4'b1010;
                MOT_DOWN:  mask = 4'b0101;
                MOT_LEFT:  mask = 4'b0110;
                MOT_RIGHT: mask = 4'b1001;
                default:   mask = 4'b0000;
            endcase
            return mask;
        end
    endfunction

endpackage

// File: hw/rtl/tcfpd_follow.sv
module tcfpd_follow #(
    parameter int SAMPLE_BITS = tcfpd_pkg::SAMPLE_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0] left_sample,
    input  logic [SAMPLE_BITS-1:0] right_sample,
    input  logic [SAMPLE_BITS-1:0] ref_left,
    input  logic [SAMPLE_BITS-1:0] ref_right,
    output tcfpd_pkg::motion_t     motion
);
    import tcfpd_pkg::*;

    // 6 * max sample fits in three extra bits
    localparam int W = SAMPLE_BITS + 3;

    logic [W-1:0] l1, r1, dl1, dr1;
    logic [W-1:0] l4, l5, l6, r4, r6, dl5, dr5;

    assign l1  = W'(left_sample);
    assign r1  = W'(right_sample);
    assign dl1 = W'(ref_left);
    assign dr1 = W'(ref_right);

    assign l4  = l1 << 2;
    assign l5  = (l1 << 2) + l1;
    assign l6  = (l1 << 2) + (l1 << 1);
    assign r4  = r1 << 2;
    assign r6  = (r1 << 2) + (r1 << 1);
    assign dl5 = (dl1 << 2) + dl1;
    assign dr5 = (dr1 << 2) + dr1;

    always_comb
    begin
        if (l5 > r6)
        begin
            motion = MOT_LEFT;
        end
        else if (l5 < r4)
        begin
            motion = MOT_RIGHT;
        end
        else if (l5 < r6 && l5 > r4)
        begin
            if (l6 < dl5 && r6 < dr5)
            begin
                motion = MOT_UP;
            end
            else if (l4 > dl5 && r4 > dr5)
            begin
                motion = MOT_DOWN;
            end
            else
            begin
                motion = MOT_STOP;
            end
        end
        else
        begin
            // on a band edge
            motion = MOT_STOP;
        end
    end

endmodule

// File: hw/rtl/tcfpd_engine.sv
module tcfpd_engine #(
    parameter int SAMPLE_BITS = tcfpd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [tcfpd_pkg::DUTY_BITS-1:0]   cfg_data,
    input  logic                              advance,
    input  tcfpd_pkg::func_t                  func,
    input  logic [7:0]                        cmd_byte,
    input  logic [SAMPLE_BITS-1:0]            left_sample,
    input  logic [SAMPLE_BITS-1:0]            right_sample,
    output tcfpd_pkg::result_t                res_next
);
    import tcfpd_pkg::*;

    logic [DUTY_BITS-1:0]   drive_duty_reg;
    logic [DUTY_BITS-1:0]   pwm_top_reg;
    logic [DUTY_BITS-1:0]   counter_reg, counter_next;
    logic [DUTY_BITS-1:0]   duty_reg [CHANNELS];
    logic [DUTY_BITS-1:0]   duty_next [CHANNELS];
    motion_t                motion_reg, motion_next;
    logic                   mode_reg, mode_next;
    logic                   refs_valid_reg, refs_valid_next;
    logic [SAMPLE_BITS-1:0] ref_left_reg, ref_left_next;
    logic [SAMPLE_BITS-1:0] ref_right_reg, ref_right_next;

    logic [DUTY_BITS:0]     count_inc;
    logic                   set_motion;
    logic [CHANNELS-1:0]    mask;
    motion_t                follow_motion;

    // The first sample after a clear is its own reference
    tcfpd_follow #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_follow (
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .ref_left     (refs_valid_reg ? ref_left_reg : left_sample),
        .ref_right    (refs_valid_reg ? ref_right_reg : right_sample),
        .motion       (follow_motion)
    );

    assign count_inc = {1'b0, counter_reg} + 1'b1;

    always_comb
    begin
        counter_next    = counter_reg;
        motion_next     = motion_reg;
        mode_next       = mode_reg;
        refs_valid_next = refs_valid_reg;
        ref_left_next   = ref_left_reg;
        ref_right_next  = ref_right_reg;
        set_motion      = 1'b0;

        case (func)
            FN_TICK:
            begin
                // wrap once past top, also when top dropped below the count
                if (count_inc > {1'b0, pwm_top_reg})
                begin
                    counter_next = '0;
                end
                else
                begin
                    counter_next = count_inc[DUTY_BITS-1:0];
                end
            end
            FN_CMD:
            begin
                if (!mode_reg)
                begin
                    set_motion      = 1'b1;
                    refs_valid_next = 1'b0;
                    case (cmd_byte)
                        CMD_UP:    motion_next = MOT_UP;
                        CMD_DOWN:  motion_next = MOT_DOWN;
                        CMD_LEFT:  motion_next = MOT_LEFT;
                        CMD_RIGHT: motion_next = MOT_RIGHT;
                        CMD_STOP:  motion_next = MOT_STOP;
                        default:
                        begin
                            // ignore unknown bytes
                            set_motion      = 1'b0;
                            refs_valid_next = refs_valid_reg;
                        end
                    endcase
                end
            end
            FN_SAMPLE:
            begin
                if (mode_reg)
                begin
                    set_motion      = 1'b1;
                    motion_next     = follow_motion;
                    refs_valid_next = 1'b1;
                    if (!refs_valid_reg)
                    begin
                        ref_left_next  = left_sample;
                        ref_right_next = right_sample;
                    end
                end
            end
            FN_TOGGLE:
            begin
                mode_next = !mode_reg;
            end
            default:
            begin
                counter_next = counter_reg;
            end
        endcase
    end

    assign mask = motion_mask(motion_next);

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (set_motion)
            begin
                duty_next[i] = mask[i] ? drive_duty_reg : '0;
            end
            else
            begin
                duty_next[i] = duty_reg[i];
            end
            res_next.pins[i] = (counter_next <= duty_next[i]);
        end
        res_next.follow = mode_next;
        res_next.motion = motion_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_duty_reg <= DRIVE_DUTY_RST;
            pwm_top_reg    <= PWM_TOP_RST;
            counter_reg    <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                duty_reg[i] <= '0;
            end
            motion_reg     <= MOT_STOP;
            mode_reg       <= 1'b0;
            refs_valid_reg <= 1'b0;
            ref_left_reg   <= '0;
            ref_right_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DRIVE_DUTY: drive_duty_reg <= cfg_data;
                    CFG_PWM_TOP:    pwm_top_reg    <= cfg_data;
                    default:        pwm_top_reg    <= pwm_top_reg;
                endcase
            end
            if (advance)
            begin
                counter_reg    <= counter_next;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    duty_reg[i] <= duty_next[i];
                end
                motion_reg     <= motion_next;
                mode_reg       <= mode_next;
                refs_valid_reg <= refs_valid_next;
                ref_left_reg   <= ref_left_next;
                ref_right_reg  <= ref_right_next;
            end
        end
    end

endmodule

// File: hw/rtl/two_coil_follower_pwm_drive_unit.sv
// Two-coil follower PWM drive. Items enter on the in channel and each one
// gives exactly one result on the out channel, carrying the four pin levels,
// the mode and the motion as they stand after that item. One item is taken
// every clock cycle for as long as results are taken: an item is held in the
// input register, and its state update and band tests run in the single logic
// pass that feeds the result register. The user must write the drive_duty and
// pwm_top registers through cfg_we / cfg_index / cfg_data only while no item
// is in flight; the block itself does not enforce this.
`include "two_coil_follower_pwm_drive_unit_macros.svh"

module two_coil_follower_pwm_drive_unit #(
    parameter int SAMPLE_BITS = tcfpd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [tcfpd_pkg::DUTY_BITS-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        func,
    input  logic [7:0]                        cmd_byte,
    input  logic [SAMPLE_BITS-1:0]            left_sample,
    input  logic [SAMPLE_BITS-1:0]            right_sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tcfpd_pkg::CHANNELS-1:0]    pin_levels,
    output logic                              follow_mode,
    output logic [2:0]                        motion
);
    import tcfpd_pkg::*;

    logic                   s1_valid_reg, s1_valid_next;
    logic [1:0]             s1_func_reg;
    logic [7:0]             s1_cmd_reg;
    logic [SAMPLE_BITS-1:0] s1_left_reg;
    logic [SAMPLE_BITS-1:0] s1_right_reg;
    logic                   out_valid_reg, out_valid_next;
    result_t                res_reg;
    result_t                res_next;
    logic                   advance;
    logic                   in_xfer;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    tcfpd_engine #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .advance      (advance),
        .func         (func_t'(s1_func_reg)),
        .cmd_byte     (s1_cmd_reg),
        .left_sample  (s1_left_reg),
        .right_sample (s1_right_reg),
        .res_next     (res_next)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payload until the next transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_func_reg  <= func;
            s1_cmd_reg   <= cmd_byte;
            s1_left_reg  <= left_sample;
            s1_right_reg <= right_sample;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pin_levels  = res_reg.pins;
    assign follow_mode = res_reg.follow;
    assign motion      = res_reg.motion;

    `TCFPD_ASSERT_NOW(a_stall_only_on_full_out, clk, rst_n, !in_ready, out_valid && !out_ready)
    `TCFPD_ASSERT_NOW(a_stop_pins_uniform, clk, rst_n, out_valid && motion == MOT_STOP,
        pin_levels == '0 || pin_levels == '1)
    `TCFPD_ASSERT_NOW(a_up_pins_paired, clk, rst_n, out_valid && motion == MOT_UP,
        pin_levels[0] == pin_levels[2] && pin_levels[1] == pin_levels[3])
    `TCFPD_ASSERT_NEXT(a_result_follows_item, clk, rst_n, s1_valid_reg && !out_valid,
        out_valid)

endmodule

// File: verif/two_coil_follower_pwm_drive_unit_tb.sv
`timescale 1ns / 1ps

module two_coil_follower_pwm_drive_unit_tb;
    import tcfpd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASE_ITEMS  = 250;

    typedef struct {
        bit                   is_cfg;
        logic                 cfg_idx;
        logic [DUTY_BITS-1:0] cfg_val;
        func_t                fn;
        logic [7:0]           cmd;
        logic [9:0]           left;
        logic [9:0]           right;
    } drive_item_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                 cfg_we = 1'b0;
    logic                 cfg_index = CFG_DRIVE_DUTY;
    logic [DUTY_BITS-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           func = FN_TICK;
    logic [7:0]           cmd_byte = '0;
    logic [9:0]           left_sample = '0;
    logic [9:0]           right_sample = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [CHANNELS-1:0]  pin_levels;
    logic                 follow_mode;
    logic [2:0]           motion;

    two_coil_follower_pwm_drive_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .cmd_byte     (cmd_byte),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pin_levels   (pin_levels),
        .follow_mode  (follow_mode),
        .motion       (motion)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Predicted drive state
    logic [DUTY_BITS-1:0] duty_setting = DRIVE_DUTY_RST;
    logic [DUTY_BITS-1:0] top_setting  = PWM_TOP_RST;
    logic [DUTY_BITS-1:0] tick_pos     = '0;
    logic [DUTY_BITS-1:0] chan_duty [CHANNELS] = '{default: '0};
    motion_t              cur_motion   = MOT_STOP;
    logic                 follow_on    = 1'b0;
    logic                 refs_held    = 1'b0;
    logic [9:0]           ref_l        = '0;
    logic [9:0]           ref_r        = '0;

    drive_item_t item_q [$];
    result_t     expected_drive_q [$];
    drive_item_t cur_item;
    int          errors = 0;
    int unsigned issued = 0;
    int unsigned finished = 0;
    int unsigned cycles = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned loaded = 0;
    int unsigned taken = 0;
    bit          calm_in = 1'b0;
    bit          calm_out = 1'b0;

    function automatic int unsigned pause_len(input bit calm);
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic void apply_motion(input motion_t m);
        logic [CHANNELS-1:0] active;
        case (m)
            MOT_UP:    active = 4'b1010;
            MOT_DOWN:  active = 4'b0101;
            MOT_LEFT:  active = 4'b0110;
            MOT_RIGHT: active = 4'b1001;
            default:   active = 4'b0000;
        endcase
        cur_motion = m;
        for (int i = 0; i < CHANNELS; i++)
            chan_duty[i] = active[i] ? duty_setting : '0;
    endfunction

    function automatic void follow_coils(input logic [9:0] l, input logic [9:0] r);
        int unsigned lv;
        int unsigned rv;
        int unsigned dl;
        int unsigned dr;
        lv = 32'(l);
        rv = 32'(r);
        apply_motion(MOT_STOP);
        if (!refs_held)
        begin
            ref_l = l;
            ref_r = r;
            refs_held = 1'b1;
        end
        dl = 32'(ref_l);
        dr = 32'(ref_r);
        if (5 * lv > 6 * rv)
            apply_motion(MOT_LEFT);
        else if (5 * lv < 4 * rv)
            apply_motion(MOT_RIGHT);
        else if (5 * lv < 6 * rv && 5 * lv > 4 * rv)
        begin
            if (6 * lv < 5 * dl && 6 * rv < 5 * dr)
                apply_motion(MOT_UP);
            else if (4 * lv > 5 * dl && 4 * rv > 5 * dr)
                apply_motion(MOT_DOWN);
        end
        // equal at a band edge: stays stopped
    endfunction

    function automatic result_t drive_step(input drive_item_t it);
        result_t  res;
        bit       known;
        logic [7:0] nxt;
        case (it.fn)
            FN_TICK:
            begin
                nxt = {1'b0, tick_pos} + 8'd1;
                tick_pos = (nxt > {1'b0, top_setting}) ? '0 : nxt[DUTY_BITS-1:0];
            end
            FN_CMD:
            begin
                if (!follow_on)
                begin
                    known = 1'b1;
                    case (it.cmd)
                        CMD_UP:    apply_motion(MOT_UP);
                        CMD_DOWN:  apply_motion(MOT_DOWN);
                        CMD_RIGHT: apply_motion(MOT_RIGHT);
                        CMD_LEFT:  apply_motion(MOT_LEFT);
                        CMD_STOP:  apply_motion(MOT_STOP);
                        default:   known = 1'b0;
                    endcase
                    if (known)
                        refs_held = 1'b0;
                end
            end
            FN_SAMPLE:
            begin
                if (follow_on)
                    follow_coils(it.left, it.right);
            end
            default:
                follow_on = !follow_on;
        endcase
        for (int i = 0; i < CHANNELS; i++)
            res.pins[i] = (tick_pos <= chan_duty[i]);
        res.follow = follow_on;
        res.motion = cur_motion;
        return res;
    endfunction

    task automatic push_item(input func_t fn, input logic [7:0] cmd,
                             input logic [9:0] l, input logic [9:0] r);
        drive_item_t it;
        it.is_cfg  = 1'b0;
        it.cfg_idx = CFG_DRIVE_DUTY;
        it.cfg_val = '0;
        it.fn      = fn;
        it.cmd     = cmd;
        it.left    = l;
        it.right   = r;
        item_q.push_back(it);
    endtask

    task automatic push_cfg(input logic idx, input logic [DUTY_BITS-1:0] val);
        drive_item_t it;
        it.is_cfg  = 1'b1;
        it.cfg_idx = idx;
        it.cfg_val = val;
        it.fn      = FN_TICK;
        it.cmd     = '0;
        it.left    = '0;
        it.right   = '0;
        item_q.push_back(it);
    endtask

    function automatic logic [9:0] near_count(input int unsigned base);
        int unsigned v;
        v = base * $urandom_range(70, 130) / 100;
        return (v > 1023) ? 10'd1023 : v[9:0];
    endfunction

    task automatic push_random_item();
        int unsigned pick;
        int unsigned base;
        logic [7:0]  cmd;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            push_item(FN_TICK, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                      10'($urandom_range(0, 1023)));
        else if (pick < 60)
        begin
            case ($urandom_range(0, 5))
                0:       cmd = CMD_UP;
                1:       cmd = CMD_DOWN;
                2:       cmd = CMD_LEFT;
                3:       cmd = CMD_RIGHT;
                4:       cmd = CMD_STOP;
                default: cmd = 8'($urandom_range(0, 255));
            endcase
            push_item(FN_CMD, cmd, 10'($urandom_range(0, 1023)),
                      10'($urandom_range(0, 1023)));
        end
        else if (pick < 92)
        begin
            // mostly pairs near one level, so the band and reference tests get exercised
            if ($urandom_range(0, 3) != 0)
            begin
                base = $urandom_range(40, 1023);
                push_item(FN_SAMPLE, 8'($urandom_range(0, 255)), near_count(base),
                          near_count(base));
            end
            else
                push_item(FN_SAMPLE, 8'($urandom_range(0, 255)),
                          10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
        end
        else
            push_item(FN_TOGGLE, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                      10'($urandom_range(0, 1023)));
    endtask

    // Driver: present pending items, write registers only with nothing in flight
    always @(posedge clk or negedge rst_n)
    begin : driver
        drive_item_t nxt;
        bit          load;
        bit          we;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            cfg_we       <= 1'b0;
            cfg_index    <= CFG_DRIVE_DUTY;
            cfg_data     <= '0;
            func         <= FN_TICK;
            cmd_byte     <= '0;
            left_sample  <= '0;
            right_sample <= '0;
        end
        else
        begin
            load = 1'b0;
            we   = 1'b0;
            if (out_valid && out_ready)
                finished++;
            if (in_valid && in_ready)
            begin
                expected_drive_q.push_back(drive_step(cur_item));
                issued++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (item_q.size() > 0)
                begin
                    if (item_q[0].is_cfg)
                    begin
                        if (issued == finished)
                        begin
                            nxt = item_q.pop_front();
                            we  = 1'b1;
                            if (nxt.cfg_idx == CFG_DRIVE_DUTY)
                                duty_setting = nxt.cfg_val;
                            else
                                top_setting = nxt.cfg_val;
                        end
                    end
                    else
                    begin
                        nxt  = item_q.pop_front();
                        load = 1'b1;
                        if (loaded % 64 == 0)
                            calm_in = ($urandom_range(0, 3) == 0);
                        loaded++;
                        gap_left = pause_len(calm_in);
                    end
                end
            end
            in_valid <= load || (in_valid && !in_ready);
            cfg_we   <= we;
            if (we)
            begin
                cfg_index <= nxt.cfg_idx;
                cfg_data  <= nxt.cfg_val;
            end
            if (load)
            begin
                cur_item     = nxt;
                func         <= nxt.fn;
                cmd_byte     <= nxt.cmd;
                left_sample  <= nxt.left;
                right_sample <= nxt.right;
            end
        end
    end

    // Monitor: take results with random stalls and check them in order
    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_drive_q.size() == 0)
                begin
                    $error("result transfer with nothing expected: pins %h mode %0d motion %0d",
                           pin_levels, follow_mode, motion);
                    errors++;
                end
                else
                begin
                    want = expected_drive_q.pop_front();
                    if (pin_levels !== want.pins)
                    begin
                        $error("pin_levels: expected %h, got %h", want.pins, pin_levels);
                        errors++;
                    end
                    if (follow_mode !== want.follow)
                    begin
                        $error("follow_mode: expected %0d, got %0d", want.follow, follow_mode);
                        errors++;
                    end
                    if (motion !== want.motion)
                    begin
                        $error("motion: expected %0d, got %0d", want.motion, motion);
                        errors++;
                    end
                end
                if (taken % 64 == 0)
                    calm_out = ($urandom_range(0, 3) == 0);
                taken++;
                stall_left = pause_len(calm_out);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("two_coil_follower_pwm_drive_unit_tb: done, errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [DUTY_BITS-1:0] duty_val;
        logic [DUTY_BITS-1:0] top_val;

        // remote commands, including ignored bytes
        push_item(FN_TICK, 8'h00, 10'd0, 10'd0);
        push_item(FN_CMD, CMD_UP, 10'd0, 10'd0);
        push_item(FN_TICK, 8'h00, 10'd0, 10'd0);
        push_item(FN_CMD, CMD_DOWN, 10'd0, 10'd0);
        push_item(FN_CMD, CMD_LEFT, 10'd0, 10'd0);
        push_item(FN_CMD, CMD_RIGHT, 10'd0, 10'd0);
        push_item(FN_CMD, 8'hFF, 10'd1023, 10'd1023);
        push_item(FN_CMD, 8'h00, 10'd0, 10'd0);
        push_item(FN_CMD, CMD_STOP, 10'd0, 10'd0);
        // follow mode: reference capture, band tests and band edges
        push_item(FN_TOGGLE, 8'h00, 10'd0, 10'd0);
        push_item(FN_CMD, CMD_UP, 10'd0, 10'd0);
        push_item(FN_SAMPLE, 8'h00, 10'd500, 10'd500);
        push_item(FN_SAMPLE, 8'h00, 10'd400, 10'd400);
        push_item(FN_SAMPLE, 8'h00, 10'd700, 10'd700);
        push_item(FN_SAMPLE, 8'h00, 10'd6, 10'd5);
        push_item(FN_SAMPLE, 8'h00, 10'd4, 10'd5);
        push_item(FN_SAMPLE, 8'h00, 10'd1023, 10'd0);
        push_item(FN_SAMPLE, 8'h00, 10'd0, 10'd1023);
        push_item(FN_SAMPLE, 8'hFF, 10'd1023, 10'd1023);
        // back to remote: motion kept, samples ignored
        push_item(FN_TOGGLE, 8'h00, 10'd0, 10'd0);
        push_item(FN_SAMPLE, 8'h00, 10'd1023, 10'd0);
        push_item(FN_CMD, CMD_UP, 10'd0, 10'd0);
        // counter left above a lowered top must wrap on the next tick
        push_cfg(CFG_DRIVE_DUTY, 7'd127);
        push_cfg(CFG_PWM_TOP, 7'd127);
        for (int i = 0; i < 4; i++)
            push_item(FN_TICK, 8'h00, 10'd0, 10'd0);
        push_cfg(CFG_PWM_TOP, 7'd1);
        push_item(FN_TICK, 8'h00, 10'd0, 10'd0);
        push_item(FN_TICK, 8'h00, 10'd0, 10'd0);
        push_cfg(CFG_DRIVE_DUTY, 7'd0);
        push_item(FN_CMD, CMD_RIGHT, 10'd0, 10'd0);
        push_item(FN_TICK, 8'h00, 10'd0, 10'd0);

        for (int p = 0; p < RANDOM_ITEMS / PHASE_ITEMS; p++)
        begin
            case (p)
                0:       begin duty_val = 7'd127; top_val = 7'd127; end
                1:       begin duty_val = 7'd0;   top_val = 7'd1;   end
                2:       begin duty_val = 7'd127; top_val = 7'd1;   end
                3:       begin duty_val = 7'd1;   top_val = 7'd127; end
                default:
                begin
                    duty_val = 7'($urandom_range(0, 127));
                    top_val  = $urandom_range(0, 1) ? 7'($urandom_range(1, 127))
                                                    : 7'($urandom_range(1, 8));
                end
            endcase
            push_cfg(CFG_DRIVE_DUTY, duty_val);
            push_cfg(CFG_PWM_TOP, top_val);
            for (int i = 0; i < PHASE_ITEMS; i++)
                push_random_item();
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (item_q.size() != 0 || in_valid || issued != finished)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_drive_q.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_drive_q.size());
            errors++;
        end
        if (errors == 0)
            $display("two_coil_follower_pwm_drive_unit_tb: done, clean");
        else
            $display("two_coil_follower_pwm_drive_unit_tb: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/tcfpd_pkg.sv
hw/rtl/tcfpd_follow.sv
hw/rtl/tcfpd_engine.sv
hw/rtl/two_coil_follower_pwm_drive_unit.sv
verif/two_coil_follower_pwm_drive_unit_tb.sv
